// ===== sv/itrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared types and constants of the signed integer to radix symbols core.
// ----------------------------------------------------------------------------
package itrs_pkg;

   typedef logic [7:0] byte_type;

   localparam byte_type CHAR_MINUS = 8'h2D;
   localparam byte_type CHAR_PLUS  = 8'h2B;

   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 64;
   localparam int RADIX_LENGTH_BITS  = 5;
   localparam int SYMBOLS_PER_WORD   = 8;
   // long-division bits retired per cycle in the back end
   localparam int DIV_BITS_PER_CYCLE = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RADIX_LENGTH = 2'd0,
      CSR_SYMBOLS_LOW  = 2'd1,
      CSR_SYMBOLS_HIGH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== sv/itrs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_front
// Configuration registers, alphabet check, and intake of values into the queue.
// ----------------------------------------------------------------------------
module itrs_front #(
   parameter int MAX_SYMBOLS = 16,
   parameter int VALUE_BITS  = 32,
   localparam int RADIX_BITS = $clog2(MAX_SYMBOLS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [itrs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [itrs_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  start,
   input  logic signed [VALUE_BITS-1:0]          req_value,
   input  logic                                  queue_full,
   output logic                                  push,
   output logic [VALUE_BITS:0]                   push_data,
   output logic [MAX_SYMBOLS*8-1:0]              symbols_o,
   output logic [RADIX_BITS-1:0]                 radix_o
);

   logic [itrs_pkg::RADIX_LENGTH_BITS-1:0] radix_length_ff;
   itrs_pkg::byte_type                     symbol_ff [MAX_SYMBOLS];
   logic [itrs_pkg::RADIX_LENGTH_BITS-1:0] radix_clamped;
   logic [RADIX_BITS-1:0]                  radix;
   logic                                   alphabet_ok;
   logic                                   accept;
   logic                                   negative;
   logic [VALUE_BITS-1:0]                  raw;
   logic [VALUE_BITS-1:0]                  magnitude;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_length_ff <= '0;
         for (int i = 0; i < MAX_SYMBOLS; i++) begin
            symbol_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            itrs_pkg::CSR_RADIX_LENGTH: begin
               radix_length_ff <= csr_wdata[itrs_pkg::RADIX_LENGTH_BITS-1:0];
            end
            itrs_pkg::CSR_SYMBOLS_LOW: begin
               for (int i = 0; i < MAX_SYMBOLS; i++) begin
                  if (i < itrs_pkg::SYMBOLS_PER_WORD) begin
                     symbol_ff[i] <= csr_wdata[(i % itrs_pkg::SYMBOLS_PER_WORD)*8 +: 8];
                  end
               end
            end
            itrs_pkg::CSR_SYMBOLS_HIGH: begin
               for (int i = 0; i < MAX_SYMBOLS; i++) begin
                  if (i >= itrs_pkg::SYMBOLS_PER_WORD) begin
                     symbol_ff[i] <= csr_wdata[(i % itrs_pkg::SYMBOLS_PER_WORD)*8 +: 8];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // clamp the radix to the alphabet storage
   always_comb begin
      if (radix_length_ff > itrs_pkg::RADIX_LENGTH_BITS'(MAX_SYMBOLS)) begin
         radix_clamped = itrs_pkg::RADIX_LENGTH_BITS'(MAX_SYMBOLS);
      end else begin
         radix_clamped = radix_length_ff;
      end
      radix = radix_clamped[RADIX_BITS-1:0];
   end

   // check of the symbols in use: at least two, no sign characters, no repeats
   always_comb begin
      alphabet_ok = (radix >= 2);
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (i < radix) begin
            if (symbol_ff[i] == itrs_pkg::CHAR_PLUS || symbol_ff[i] == itrs_pkg::CHAR_MINUS) begin
               alphabet_ok = 1'b0;
            end
         end
         for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
            if (j < radix && symbol_ff[i] == symbol_ff[j]) begin
               alphabet_ok = 1'b0;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         symbols_o[i*8 +: 8] = symbol_ff[i];
      end
   end

   assign radix_o   = radix;
   assign accept    = start && !queue_full;
   // drop values that meet an invalid alphabet
   assign push      = accept && alphabet_ok;
   assign raw       = req_value;
   assign negative  = raw[VALUE_BITS-1];
   assign magnitude = negative ? (~raw + 1'b1) : raw;
   assign push_data = {negative, magnitude};

endmodule

// ===== sv/itrs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_queue
// Two-entry queue between the intake front end and the conversion back end.
// ----------------------------------------------------------------------------
module itrs_queue #(
   parameter int WIDTH = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output itrs_pkg::queue_status_type status
);

   localparam int DEPTH     = 2;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff           <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue fill count beyond depth");

endmodule

// ===== sv/itrs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_back
// Digit extraction by iterative long division and emission of characters.
// ----------------------------------------------------------------------------
module itrs_back #(
   parameter int MAX_SYMBOLS = 16,
   parameter int VALUE_BITS  = 32,
   localparam int RADIX_BITS = $clog2(MAX_SYMBOLS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [RADIX_BITS-1:0]      radix_i,
   input  logic [MAX_SYMBOLS*8-1:0]   symbols_i,
   input  itrs_pkg::queue_status_type queue_status,
   input  logic [VALUE_BITS:0]        pop_data,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic [7:0]                 rsp_character,
   output logic                       rsp_last
);

   localparam int STEP       = itrs_pkg::DIV_BITS_PER_CYCLE;
   localparam int DIGIT_BITS = $clog2(MAX_SYMBOLS);
   localparam int CMP_BITS   = DIGIT_BITS + 1;
   localparam int DIV_CYCLES = (VALUE_BITS + STEP - 1) / STEP;
   localparam int WORK_BITS  = DIV_CYCLES * STEP;
   localparam int STEP_BITS  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
   localparam int IDX_BITS   = $clog2(VALUE_BITS);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      EMIT
   } state_type;

   state_type             state_ff;
   logic [WORK_BITS-1:0]  work_ff;
   logic [DIGIT_BITS-1:0] rem_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [CNT_BITS-1:0]   ndig_ff;
   logic [DIGIT_BITS-1:0] digit_ff [VALUE_BITS];
   logic                  rsp_strobe_ff;
   itrs_pkg::byte_type    rsp_character_ff;
   logic                  rsp_last_ff;

   logic [WORK_BITS-1:0]  quot_step;
   logic [DIGIT_BITS-1:0] rem_step;
   logic [CMP_BITS-1:0]   partial;
   logic [CMP_BITS-1:0]   radix_ext;
   logic [CNT_BITS-1:0]   cnt_minus;
   logic [IDX_BITS-1:0]   wr_idx;
   logic [IDX_BITS-1:0]   rd_idx;
   logic [DIGIT_BITS-1:0] digit_rd;
   itrs_pkg::byte_type    sym_char;

   assign radix_ext = CMP_BITS'(radix_i);

   // retire STEP quotient bits of restoring division per cycle
   always_comb begin
      quot_step = work_ff;
      rem_step  = rem_ff;
      partial   = '0;
      for (int s = 0; s < STEP; s++) begin
         partial   = {rem_step, quot_step[WORK_BITS-1]};
         quot_step = {quot_step[WORK_BITS-2:0], 1'b0};
         if (partial >= radix_ext) begin
            partial      = partial - radix_ext;
            quot_step[0] = 1'b1;
         end
         rem_step = partial[DIGIT_BITS-1:0];
      end
   end

   assign cnt_minus = ndig_ff - 1'b1;
   assign wr_idx    = ndig_ff[IDX_BITS-1:0];
   assign rd_idx    = cnt_minus[IDX_BITS-1:0];
   assign digit_rd  = digit_ff[rd_idx];

   always_comb begin
      sym_char = '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (DIGIT_BITS'(i) == digit_rd) begin
            sym_char = symbols_i[i*8 +: 8];
         end
      end
   end

   assign pop = (state_ff == IDLE) && !queue_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rsp_strobe_ff <= 1'b0;
         step_ff       <= '0;
         ndig_ff       <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (!queue_status.empty) begin
                  work_ff          <= WORK_BITS'(pop_data[VALUE_BITS-1:0]);
                  rem_ff           <= '0;
                  step_ff          <= '0;
                  ndig_ff          <= '0;
                  state_ff         <= DIVIDE;
                  // a negative value opens with the minus sign
                  rsp_strobe_ff    <= pop_data[VALUE_BITS];
                  rsp_character_ff <= itrs_pkg::CHAR_MINUS;
                  rsp_last_ff      <= 1'b0;
               end else begin
                  rsp_strobe_ff <= 1'b0;
               end
            end
            DIVIDE: begin
               rsp_strobe_ff <= 1'b0;
               work_ff       <= quot_step;
               if (step_ff == STEP_BITS'(DIV_CYCLES - 1)) begin
                  step_ff          <= '0;
                  rem_ff           <= '0;
                  digit_ff[wr_idx] <= rem_step;
                  ndig_ff          <= ndig_ff + 1'b1;
                  if (quot_step == '0) begin
                     state_ff <= EMIT;
                  end
               end else begin
                  rem_ff  <= rem_step;
                  step_ff <= step_ff + 1'b1;
               end
            end
            EMIT: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_character_ff <= sym_char;
               rsp_last_ff      <= (ndig_ff == CNT_BITS'(1));
               ndig_ff          <= cnt_minus;
               if (ndig_ff == CNT_BITS'(1)) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   a_last_closes_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_ff) |-> state_ff == IDLE)
      else $error("final character shown while conversion still running");

   a_digit_count_bound: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= CNT_BITS'(VALUE_BITS))
      else $error("digit stack overflow");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == EMIT |-> ndig_ff != '0)
      else $error("emission with empty digit stack");

endmodule

// ===== sv/signed_int_to_radix_symbols_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_symbols_core
// Converts signed integers to text in a radix set by a configured alphabet.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ---------------------------
//  request  in         start & !busy             req_value
//  result   out        rsp_strobe, one cycle     rsp_character, rsp_last
//  csr      in         csr_we                    csr_index, csr_wdata
//
//  A value enters the queue through a register; each digit then comes from long
//  division at 8 bits per cycle, and the digits go out in reverse order. A sign
//  character goes out while the first digit divides. Reset is synchronous and
//  clears the configuration and control registers and the queue; the alphabet
//  is invalid after reset. The receiver cannot stall: busy rises only when the
//  two-entry queue is full.
//
module signed_int_to_radix_symbols_core #(
   parameter int MAX_SYMBOLS = 16,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [itrs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [itrs_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                start,
   input  logic signed [VALUE_BITS-1:0]        req_value,
   output logic                                busy,
   output logic                                rsp_strobe,
   output logic [7:0]                          rsp_character,
   output logic                                rsp_last
);

   localparam int RADIX_BITS = $clog2(MAX_SYMBOLS + 1);

   // front end outputs: queue entry is {negative, magnitude}
   logic                       push;
   logic [VALUE_BITS:0]        push_data;
   logic [MAX_SYMBOLS*8-1:0]   symbols;
   logic [RADIX_BITS-1:0]      radix;

   // queue to back end
   logic                       pop;
   logic [VALUE_BITS:0]        pop_data;
   itrs_pkg::queue_status_type queue_status;

   // hold requests off only while the queue has no room
   assign busy = queue_status.full;

   // intake: register file, alphabet check, sign split; drop on a bad alphabet
   itrs_front #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .start      (start),
      .req_value  (req_value),
      .queue_full (queue_status.full),
      .push       (push),
      .push_data  (push_data),
      .symbols_o  (symbols),
      .radix_o    (radix)
   );

   // decouple intake from conversion so each side stalls on its own
   itrs_queue #(
      .WIDTH (VALUE_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   // conversion: divide out digits least significant first, emit in reverse
   itrs_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .radix_i       (radix),
      .symbols_i     (symbols),
      .queue_status  (queue_status),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_int_to_radix_symbols_core: a directed table
// of alphabets and edge values, then random alphabets and values, with every
// character compared against typed text or an in-bench conversion of the value.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          MAX_SYMBOLS   = 16;
   localparam int          VALUE_BITS    = 32;
   // Longest quiet spell: a binary value of 32 digits is slow to convert, and
   // the two-entry queue plus the one in flight may all be silent work.
   localparam int          DRAIN_CYCLES  = 600;
   localparam int          RANDOM_ITEMS  = 100;
   localparam logic [1:0]  CSR_INDEX_UNUSED = 2'd3;

   // Alphabets spelled out byte by byte, symbol 0 in the low byte.
   localparam logic [63:0] DIGITS_0_TO_7 = 64'h3736353433323130;  // "01234567"
   localparam logic [63:0] DIGITS_8_TO_F = 64'h6665646362613938;  // "89abcdef"

   typedef enum logic [1:0] {
      STEP_WRITE,    // register write, made once the core is quiet
      STEP_LITERAL,  // value whose text is typed in the table
      STEP_CHECKED   // value whose text comes from the conversion below
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [1:0]    index;
      logic [63:0]   data;
      logic [31:0]   value;
      string         text;
   } directed_step_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } char_beat_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [1:0]             csr_index;
   logic [63:0]            csr_wdata;
   logic                   start;
   logic [VALUE_BITS-1:0]  req_value;
   logic                   busy;
   logic                   rsp_strobe;
   logic [7:0]             rsp_character;
   logic                   rsp_last;

   // Side-band for the value now on offer: typed text or computed text.
   logic                   req_literal;
   string                  req_text;

   // Shadow of the alphabet registers, as last written.
   logic [4:0]             radix_setting;
   logic [63:0]            alphabet_low;
   logic [63:0]            alphabet_high;

   char_beat_type          pending_chars [$];
   int                     error_count;
   int                     idle_pct;

   directed_step_type directed_steps [$] = '{
      // After reset the alphabet is empty, so nothing may come out.
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd7, ""},
      // Decimal.
      '{STEP_WRITE, itrs_pkg::CSR_RADIX_LENGTH, 64'd10, 32'd0, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_LOW, DIGITS_0_TO_7, 32'd0, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_HIGH, DIGITS_8_TO_F, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd0, "0"},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'h7FFF_FFFF, "2147483647"},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'h8000_0000, "-2147483648"},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'hFFFF_FFFF, "-1"},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd10, "10"},
      // Hexadecimal, the full sixteen symbols.
      '{STEP_WRITE, itrs_pkg::CSR_RADIX_LENGTH, 64'd16, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'h7FFF_FFFF, "7fffffff"},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'h8000_0000, "-80000000"},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'hFFFF_FF01, "-ff"},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'hDEAD_BEEF, "-21524111"},
      // Binary: the longest texts.
      '{STEP_WRITE, itrs_pkg::CSR_RADIX_LENGTH, 64'd2, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd5, "101"},
      '{STEP_CHECKED, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'h7FFF_FFFF, ""},
      '{STEP_CHECKED, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'h8000_0000, ""},
      // Radix above the symbol count is clamped to sixteen; upper data bits
      // of the length write are dropped.
      '{STEP_WRITE, itrs_pkg::CSR_RADIX_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd255, "ff"},
      // A write to an index with no register behind it changes nothing.
      '{STEP_WRITE, CSR_INDEX_UNUSED, 64'd2, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd255, "ff"},
      // Radix of one is no alphabet.
      '{STEP_WRITE, itrs_pkg::CSR_RADIX_LENGTH, 64'd1, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd5, ""},
      // Radix three: minus sign, plus sign and a repeat each spoil it.
      '{STEP_WRITE, itrs_pkg::CSR_RADIX_LENGTH, 64'd3, 32'd0, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_LOW, 64'h0000_0000_0032_2D30, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd5, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_LOW, 64'h0000_0000_0032_2B30, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd5, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_LOW, 64'h0000_0000_0030_3130, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd5, ""},
      // Bad symbols beyond the radix do not matter.
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_LOW, 64'h0000_2D2B_0032_3130, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd5, "12"},
      // A zero byte is an ordinary symbol.
      '{STEP_WRITE, itrs_pkg::CSR_RADIX_LENGTH, 64'd2, 32'd0, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_LOW, 64'h0000_0000_0000_4100, 32'd0, ""},
      '{STEP_CHECKED, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd2, ""},
      '{STEP_CHECKED, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'h8000_0000, ""},
      // Sixteen symbols: a repeat or a plus sign in the top symbol spoils it.
      '{STEP_WRITE, itrs_pkg::CSR_RADIX_LENGTH, 64'd16, 32'd0, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_LOW, DIGITS_0_TO_7, 32'd0, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_HIGH, 64'h3065_6463_6261_3938, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd100, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_HIGH, 64'h2B65_6463_6261_3938, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd100, ""},
      '{STEP_WRITE, itrs_pkg::CSR_SYMBOLS_HIGH, DIGITS_8_TO_F, 32'd0, ""},
      '{STEP_LITERAL, itrs_pkg::CSR_RADIX_LENGTH, 64'd0, 32'd1, "1"}
   };

   signed_int_to_radix_symbols_core #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .start         (start),
      .req_value     (req_value),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("** signed_int_to_radix_symbols_core: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Conversion in bench terms
   // ------------------------------------------------------------------------

   function automatic logic [7:0] symbol_of(int unsigned idx);
      logic [63:0] word;
      word = (idx < 8) ? alphabet_low : alphabet_high;
      return word[(idx % 8) * 8 +: 8];
   endfunction

   // Length register clamped to the number of symbol slots.
   function automatic int unsigned radix_in_use();
      int unsigned r;
      r = 32'(radix_setting);
      if (r > MAX_SYMBOLS) r = MAX_SYMBOLS;
      return r;
   endfunction

   // At least two symbols, none repeated, no sign characters.
   function automatic bit alphabet_usable(int unsigned r);
      logic [7:0] sym;
      if (r < 2) return 1'b0;
      for (int unsigned i = 0; i < r; i++) begin
         sym = symbol_of(i);
         if (sym == itrs_pkg::CHAR_PLUS || sym == itrs_pkg::CHAR_MINUS) return 1'b0;
         for (int unsigned j = i + 1; j < r; j++) begin
            if (symbol_of(j) == sym) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Append the characters that one value must produce, sign first, then
   // digits most significant first, last on the final one.
   function automatic void queue_conversion(logic [VALUE_BITS-1:0] value);
      int unsigned           r;
      logic [VALUE_BITS-1:0] magnitude;
      int unsigned           digit_idx [VALUE_BITS+1];
      int                    count;
      char_beat_type         beat;
      r = radix_in_use();
      if (!alphabet_usable(r)) return;
      if (value[VALUE_BITS-1]) begin
         beat.character = itrs_pkg::CHAR_MINUS;
         beat.last      = 1'b0;
         pending_chars.push_back(beat);
         magnitude = ~value + 1'b1;
      end else begin
         magnitude = value;
      end
      count = 0;
      do begin
         digit_idx[count] = magnitude % r;
         magnitude        = magnitude / r;
         count++;
      end while (magnitude != 0);
      for (int k = count - 1; k >= 0; k--) begin
         beat.character = symbol_of(digit_idx[k]);
         beat.last      = (k == 0);
         pending_chars.push_back(beat);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checking and expectation capture, both on the rising edge
   // ------------------------------------------------------------------------

   task automatic report_mismatch(string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : track_characters
      char_beat_type want;
      char_beat_type beat;
      if (!reset) begin
         // Check the character on the ports against the oldest one owed.
         if (rsp_strobe === 1'b1) begin
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character %h last %b",
                                         rsp_character, rsp_last));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_character !== want.character)
                  report_mismatch($sformatf("character %h, expected %h",
                                            rsp_character, want.character));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b on character %h, expected %b",
                                            rsp_last, rsp_character, want.last));
            end
         end
         // A transfer on the request side: record what it must produce.
         if (start && !busy) begin
            if (req_literal) begin
               for (int i = 0; i < req_text.len(); i++) begin
                  beat.character = req_text[i];
                  beat.last      = (i == req_text.len() - 1);
                  pending_chars.push_back(beat);
               end
            end else begin
               queue_conversion(req_value);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driving: every task is entered and left just after a falling edge
   // ------------------------------------------------------------------------

   // Drop start, wait for every owed character, then give the core time to
   // finish any silent work before the registers change.
   task automatic settle();
      start <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         itrs_pkg::CSR_RADIX_LENGTH:
            radix_setting = data[itrs_pkg::RADIX_LENGTH_BITS-1:0];
         itrs_pkg::CSR_SYMBOLS_LOW:  alphabet_low  = data;
         itrs_pkg::CSR_SYMBOLS_HIGH: alphabet_high = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Offer one value and hold it until the transfer. Start is left high so
   // that a following value goes out back to back; callers drop it otherwise.
   task automatic send_value(logic [VALUE_BITS-1:0] value, bit literal, string text);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 90)) @(negedge clock);
         else                        repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start       <= 1'b1;
      req_value   <= value;
      req_literal <= literal;
      req_text    <= text;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   // Random alphabet of distinct, sign-free symbols, spoilt now and then.
   task automatic program_random_alphabet(output bit usable);
      logic [7:0]  syms [MAX_SYMBOLS];
      logic [63:0] low_word;
      logic [63:0] high_word;
      logic [63:0] length_word;
      int unsigned r;
      int unsigned pos;
      bit          clash;
      r = $urandom_range(2, MAX_SYMBOLS);
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (i < r) begin
            do begin
               syms[i] = 8'($urandom);
               clash   = (syms[i] == itrs_pkg::CHAR_PLUS ||
                          syms[i] == itrs_pkg::CHAR_MINUS);
               for (int j = 0; j < i; j++) clash |= (syms[j] == syms[i]);
            end while (clash);
         end else begin
            syms[i] = 8'($urandom);
         end
      end
      case ($urandom_range(7))
         0: r = $urandom_range(1);
         1: begin
            pos       = $urandom_range(0, r - 1);
            syms[pos] = $urandom_range(1) ? itrs_pkg::CHAR_PLUS : itrs_pkg::CHAR_MINUS;
         end
         2: begin
            pos       = $urandom_range(1, r - 1);
            syms[pos] = syms[$urandom_range(0, pos - 1)];
         end
         default: ;
      endcase
      // Exercise the clamp on a full alphabet.
      if (r == MAX_SYMBOLS && $urandom_range(1)) r = $urandom_range(17, 31);
      for (int i = 0; i < 8; i++) begin
         low_word[i*8 +: 8]  = syms[i];
         high_word[i*8 +: 8] = syms[i+8];
      end
      length_word = {$urandom, $urandom};
      length_word[itrs_pkg::RADIX_LENGTH_BITS-1:0] = r[itrs_pkg::RADIX_LENGTH_BITS-1:0];
      write_csr(itrs_pkg::CSR_SYMBOLS_LOW, low_word);
      write_csr(itrs_pkg::CSR_SYMBOLS_HIGH, high_word);
      write_csr(itrs_pkg::CSR_RADIX_LENGTH, length_word);
      usable = alphabet_usable(radix_in_use());
   endtask

   function automatic logic [VALUE_BITS-1:0] next_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(5))
         0, 1: v = $urandom;
         2:    v = $urandom_range(0, 40) - 20;
         3: begin
            case ($urandom_range(4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0001;
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
            if ($urandom_range(1)) v = ~v + 1'b1;
         end
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   initial begin : stimulus
      int idle_modes [3];
      int usable_items;
      int phase;
      int burst;
      bit usable;

      idle_modes    = '{0, 59, 33};
      reset         <= 1'b1;
      start         <= 1'b0;
      req_value     <= '0;
      req_literal   <= 1'b0;
      req_text      <= "";
      csr_we        <= 1'b0;
      csr_index     <= itrs_pkg::CSR_RADIX_LENGTH;
      csr_wdata     <= '0;
      radix_setting = '0;
      alphabet_low  = '0;
      alphabet_high = '0;
      error_count   = 0;
      idle_pct      = 0;

      // Hold reset, then release it on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table, back to back.
      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            STEP_WRITE: begin
               settle();
               write_csr(directed_steps[i].index, directed_steps[i].data);
            end
            STEP_LITERAL: send_value(directed_steps[i].value, 1'b1, directed_steps[i].text);
            default:      send_value(directed_steps[i].value, 1'b0, "");
         endcase
      end

      // Random phases: a fresh alphabet each, rotating the sender's idling.
      usable_items = 0;
      phase        = 0;
      while (usable_items < RANDOM_ITEMS) begin
         idle_pct = idle_modes[phase % 3];
         settle();
         program_random_alphabet(usable);
         burst = usable ? 25 : 4;
         for (int k = 0; k < burst; k++) begin
            // Once, hold off mid-phase until the core has drained.
            if (phase == 2 && k == burst / 2) begin
               start <= 1'b0;
               while (pending_chars.size() != 0) @(negedge clock);
            end
            send_value(next_value(), 1'b0, "");
         end
         if (usable) usable_items += burst;
         phase++;
      end

      settle();
      if (error_count == 0) begin
         $display("** signed_int_to_radix_symbols_core: PASSED **");
      end else begin
         $display("** signed_int_to_radix_symbols_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/itrs_pkg.sv
sv/itrs_front.sv
sv/itrs_queue.sv
sv/itrs_back.sv
sv/signed_int_to_radix_symbols_core.sv
tb/testbench.sv
